/* hw/rtl/scanner_pattern_led_frames_top_defines.svh */
// Assertion macros shared by the scanner RTL.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef SCANNER_PATTERN_LED_FRAMES_TOP_DEFINES_SVH
`define SCANNER_PATTERN_LED_FRAMES_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define SPL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SPL_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/spl_pkg.sv */
// Shared types and constants for the LED strip scanner.
// No dependencies.
package spl_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned WORD_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd2;

    localparam logic [7:0] PASS_COUNT_RST = 8'd4;
    localparam logic [7:0] HEAD_LEVEL_RST = 8'd128;
    localparam logic [4:0] BRIGHTNESS_RST = 5'd31;

    localparam logic [2:0] PIXEL_MARK = 3'b111;
    localparam logic [WORD_W-1:0] START_WORD = 32'h0000_0000;
    localparam logic [WORD_W-1:0] END_WORD = 32'hFFFF_FFFF;

    typedef struct packed {
        logic take;
        logic ld_start;
        logic ld_pix;
        logic ld_end;
    } spl_cmd_t;

    typedef struct packed {
        logic finished;
        logic out_free;
        logic last_pix;
    } spl_stat_t;

endpackage

/* hw/rtl/spl_ctrl.sv */
// Frame sequencer for the LED strip scanner.
// Depends on spl_pkg for the command and status structs.
module spl_ctrl import spl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      restart,
    input  spl_stat_t stat,
    output logic      s_tready,
    output spl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_PIX   = 4'b0100,
        ST_END   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.take = 1'b1;
                    if (restart || !stat.finished) begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                if (stat.out_free) begin
                    cmd.ld_start = 1'b1;
                    state_next = ST_PIX;
                end
            end
            ST_PIX: begin
                if (stat.out_free) begin
                    cmd.ld_pix = 1'b1;
                    if (stat.last_pix) begin
                        state_next = ST_END;
                    end
                end
            end
            ST_END: begin
                if (stat.out_free) begin
                    cmd.ld_end = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/spl_dp.sv */
// Datapath of the LED strip scanner: settings, dot state, red level store and output register.
// Depends on spl_pkg and the assertion macros header.
`include "scanner_pattern_led_frames_top_defines.svh"

module spl_dp import spl_pkg::*; #(
    parameter int unsigned PIXELS = 17
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  restart,
    input  spl_cmd_t              cmd,
    output spl_stat_t             stat,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [WORD_W-1:0]     m_tdata,
    output logic                  m_tlast
);

    localparam int unsigned POS_W = $clog2(PIXELS);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PIXELS - 1);

    logic [7:0] pass_count_reg;
    logic [7:0] head_level_reg;
    logic [4:0] brightness_reg;

    logic [POS_W-1:0] pos_reg, pos_next, pos_step;
    logic             down_reg, down_next;
    logic [7:0]       passes_reg, passes_next;
    logic             fin_reg, fin_next;
    logic             mode_restart_reg;

    logic [7:0]       red_mem [PIXELS];
    logic [PIXELS-1:0] valid_reg;
    logic [7:0]       rd_mem_reg;
    logic             rd_valid_reg;
    logic [7:0]       rd_data;
    logic [POS_W-1:0] idx_reg, idx_next, rd_addr;
    logic [7:0]       new_val;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic              out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_count_reg <= PASS_COUNT_RST;
            head_level_reg <= HEAD_LEVEL_RST;
            brightness_reg <= BRIGHTNESS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PASS_COUNT: pass_count_reg <= cfg_data;
                REG_HEAD_LEVEL: head_level_reg <= cfg_data;
                REG_BRIGHTNESS: brightness_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        pos_next = pos_reg;
        down_next = down_reg;
        passes_next = passes_reg;
        fin_next = fin_reg;
        pos_step = pos_reg;
        if (down_reg) begin
            if (pos_reg != '0) begin
                pos_step = pos_reg - 1'b1;
            end
        end else if (pos_reg != POS_LAST) begin
            pos_step = pos_reg + 1'b1;
        end
        if (restart) begin
            pos_next = '0;
            down_next = 1'b0;
            passes_next = pass_count_reg;
            fin_next = 1'b0;
        end else if (!fin_reg) begin
            pos_next = pos_step;
            if (pos_step == '0) begin
                down_next = 1'b0;
                if (passes_reg != '0) begin
                    passes_next = passes_reg - 1'b1;
                    fin_next = (passes_reg == 8'd1);
                end
            end
            if (pos_step == POS_LAST) begin
                down_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            down_reg <= 1'b0;
            passes_reg <= PASS_COUNT_RST;
            fin_reg <= 1'b0;
            mode_restart_reg <= 1'b0;
        end else if (cmd.take) begin
            pos_reg <= pos_next;
            down_reg <= down_next;
            passes_reg <= passes_next;
            fin_reg <= fin_next;
            mode_restart_reg <= restart;
        end
    end

    assign idx_next = (idx_reg == POS_LAST) ? '0 : idx_reg + 1'b1;
    assign rd_addr = cmd.ld_pix ? idx_next : idx_reg;
    assign rd_data = rd_valid_reg ? rd_mem_reg : 8'h00;

    always_comb begin
        if (mode_restart_reg) begin
            new_val = (idx_reg == '0) ? head_level_reg : 8'h00;
        end else begin
            new_val = (idx_reg == pos_reg) ? head_level_reg : {1'b0, rd_data[7:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_pix) begin
            red_mem[idx_reg] <= new_val;
        end
        rd_mem_reg <= red_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            if (cmd.ld_pix) begin
                valid_reg[idx_reg] <= 1'b1;
                idx_reg <= idx_next;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign stat.finished = fin_reg;
    assign stat.out_free = !out_valid_reg || m_tready;
    assign stat.last_pix = (idx_reg == POS_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.ld_start || cmd.ld_pix || cmd.ld_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_start) begin
            out_word_reg <= START_WORD;
            out_last_reg <= 1'b0;
        end else if (cmd.ld_pix) begin
            out_word_reg <= {PIXEL_MARK, brightness_reg, 8'h00, 8'h00, new_val};
            out_last_reg <= 1'b0;
        end else if (cmd.ld_end) begin
            out_word_reg <= END_WORD;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_word_reg;
    assign m_tlast = out_last_reg;

    `SPL_ASSERT_NEXT(a_start_word, aclk, aresetn, cmd.ld_start,
        out_valid_reg && out_word_reg == START_WORD && !out_last_reg)
    `SPL_ASSERT_NOW(a_last_is_end, aclk, aresetn, out_valid_reg && out_last_reg,
        out_word_reg == END_WORD)
    `SPL_ASSERT_NOW(a_fin_no_passes, aclk, aresetn, fin_reg, passes_reg == '0)

endmodule

/* hw/rtl/scanner_pattern_led_frames_top.sv */
// After a tick beat is accepted, the sequencer enters its start state and, once the output
// is free, loads the start word. Ticks are taken only while idle. A frame gives one word
// and one red store read per cycle with no back-pressure; a finished advance tick sends no frame.
// Reset is synchronous and active low; it restores the register defaults, the dot state
// and an all-zero red store at once, with no clearing pass.
module scanner_pattern_led_frames_top import spl_pkg::*; #(
    parameter int unsigned PIXELS = 17
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,  // [0] restart, [7:1] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [WORD_W-1:0]     m_tdata,  // [31:0] frame_word
    output logic                  m_tlast
);

    spl_cmd_t  cmd;
    spl_stat_t stat;

    spl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .restart  (s_tdata[0]),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    spl_dp #(
        .PIXELS (PIXELS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .restart   (s_tdata[0]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
